// File: rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL.
// Stand-alone header with no dependencies; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BCBA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("allocator assertion failed");

// Consequent that must hold in the same cycle as the antecedent.
`define BCBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define BCBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

// File: rtl/core/bcba_pkg.sv
// Package of the bitmap contiguous block allocator: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package bcba_pkg;

   localparam int ADDR_W       = 48;
   localparam int SIZE_W       = 25;
   localparam int BS_W         = 17;
   localparam int BC_W         = 9;
   localparam int STATUS_W     = 2;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 48;
   localparam int DIV_W        = 48;
   localparam int DIV_CNT_W    = 6;

   localparam int MAX_BLOCKS_DEFAULT = 256;

   localparam logic [BS_W-1:0]   BLOCK_SIZE_RESET  = BS_W'(64);
   localparam logic [BC_W-1:0]   BLOCK_COUNT_RESET = BC_W'(256);
   localparam logic [ADDR_W-1:0] POOL_BASE_RESET   = '0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_RUN  = 2'd1,
      STATUS_ZERO    = 2'd2,
      STATUS_OUTSIDE = 2'd3
   } bcba_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_SIZE  = 2'd0,
      CSR_BLOCK_COUNT = 2'd1,
      CSR_POOL_BASE   = 2'd2
   } bcba_csr_type;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } bcba_func_type;

   typedef enum logic {
      DIVSRC_CEIL   = 1'b0,
      DIVSRC_OFFSET = 1'b1
   } bcba_divsrc_type;

   typedef enum logic [3:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_PREP,
      STATE_DIV_NEED,
      STATE_SCAN,
      STATE_DIV_FIRST,
      STATE_DIV_SPAN,
      STATE_WRITE,
      STATE_MUL,
      STATE_DONE
   } bcba_state_type;

   typedef struct packed {
      logic            req_load;
      logic            div_start;
      bcba_divsrc_type div_src;
      logic            need_load;
      logic            first_load;
      logic            scan_init;
      logic            scan_step;
      logic            wr_load_alloc;
      logic            wr_load_free;
      logic            wr_step;
      logic            mul_load;
      logic            rsp_load;
      bcba_status_type rsp_status;
   } bcba_cmd_type;

   typedef struct packed {
      logic req_zero;
      logic req_free;
      logic below_base;
      logic div_done;
      logic quot_gt_cnt;
      logic quot_ge_cnt;
      logic scan_found;
      logic scan_exhausted;
      logic wr_last;
      logic rsp_free;
   } bcba_sts_type;

endpackage

// File: rtl/core/bcba_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module bcba_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/bcba_divider.sv
// Restoring divider, one quotient bit per cycle, for block size divisions.
// Depends on bcba_pkg.
module bcba_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bcba_pkg::DIV_W-1:0] dividend,
   input  logic [bcba_pkg::BS_W-1:0]  divisor,
   output logic                       done,
   output logic [bcba_pkg::DIV_W-1:0] quotient
);
   import bcba_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     quot_ff, quot_in;
   logic [BS_W-1:0]      rem_ff, rem_in;
   logic [BS_W:0]        trial;
   logic [BS_W:0]        diff;

   always_comb begin
      trial    = {rem_ff, quot_ff[DIV_W-1]};
      diff     = trial - {1'b0, divisor};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         quot_in  = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in  = diff[BS_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[BS_W-1:0];
            quot_in = {quot_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: rtl/core/bcba_datapath.sv
// Datapath of the allocator: configuration registers, request and response
// registers, in-use map RAM, scan and write counters, divider and multiplier.
// Depends on bcba_pkg, bcba_ram and bcba_divider.
module bcba_datapath #(
   parameter int MAX_BLOCKS = bcba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [bcba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcba_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            req_func,
   input  logic [bcba_pkg::SIZE_W-1:0]     req_size_bytes,
   input  logic [bcba_pkg::ADDR_W-1:0]     req_address,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [bcba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bcba_pkg::ADDR_W-1:0]     rsp_region_address,
   input  bcba_pkg::bcba_cmd_type          cmd,
   output bcba_pkg::bcba_sts_type          sts
);
   import bcba_pkg::*;

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W = (CNT_W > BC_W) ? CNT_W : BC_W;
   localparam int MUL_W = BS_W + IDX_W;

   logic [BS_W-1:0]     bs_ff, bs_in;
   logic [BC_W-1:0]     bc_ff, bc_in;
   logic [ADDR_W-1:0]   base_ff, base_in;
   logic                func_ff, func_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CNT_W-1:0]    need_ff, need_in;
   logic [IDX_W-1:0]    first_ff, first_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]    tag_ff, tag_in;
   logic                tag_vld_ff, tag_vld_in;
   logic [CNT_W-1:0]    run_ff, run_in;
   logic [IDX_W-1:0]    start_ff, start_in;
   logic [CNT_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]    wr_end_ff, wr_end_in;
   logic                wr_bit_ff, wr_bit_in;
   logic [MUL_W-1:0]    prod_ff, prod_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_region_ff, rsp_region_in;

   logic [BS_W-1:0]   bs_eff;
   logic [CNT_W-1:0]  cnt_eff;
   logic [DIV_W-1:0]  dividend;
   logic [DIV_W-1:0]  quotient;
   logic              div_done;
   logic [0:0]        map_rdata;
   logic [CNT_W-1:0]  run_next;
   logic [IDX_W-1:0]  start_next;
   logic              scan_found;
   logic              scan_exhausted;
   logic              quot_ge_cnt;
   logic [CNT_W:0]    span_sum;
   logic [CNT_W-1:0]  span_end;

   assign bs_eff  = (bs_ff == '0) ? BS_W'(1) : bs_ff;
   assign cnt_eff = (CMP_W'(bc_ff) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                         : CNT_W'(bc_ff);

   assign dividend = (cmd.div_src == DIVSRC_OFFSET) ? (addr_ff - base_ff)
                   : (DIV_W'(size_ff) + DIV_W'(bs_eff) - DIV_W'(1));

   bcba_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (bs_eff),
      .done     (div_done),
      .quotient (quotient)
   );

   bcba_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BLOCKS)
   ) u_map (
      .clock (clock),
      .we    (cmd.wr_step),
      .waddr (wr_idx_ff[IDX_W-1:0]),
      .wdata (wr_bit_ff),
      .raddr (rd_idx_ff[IDX_W-1:0]),
      .rdata (map_rdata)
   );

   assign run_next       = map_rdata[0] ? '0 : run_ff + CNT_W'(1);
   assign start_next     = (run_ff == '0) ? tag_ff : start_ff;
   assign scan_found     = tag_vld_ff && !map_rdata[0] && (run_next == need_ff);
   assign scan_exhausted = tag_vld_ff && !scan_found
                           && ((CNT_W'(tag_ff) + CNT_W'(1)) == cnt_eff);

   assign quot_ge_cnt = quotient >= DIV_W'(cnt_eff);
   assign span_sum    = (CNT_W + 1)'(first_ff) + (CNT_W + 1)'(quotient[CNT_W-1:0]);
   assign span_end    = (quot_ge_cnt || (span_sum > (CNT_W + 1)'(cnt_eff))) ? cnt_eff
                                                                           : span_sum[CNT_W-1:0];

   always_comb begin
      bs_in         = bs_ff;
      bc_in         = bc_ff;
      base_in       = base_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      need_in       = need_ff;
      first_in      = first_ff;
      rd_idx_in     = rd_idx_ff;
      tag_in        = tag_ff;
      tag_vld_in    = tag_vld_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      wr_idx_in     = wr_idx_ff;
      wr_end_in     = wr_end_ff;
      wr_bit_in     = wr_bit_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_region_in = rsp_region_ff;

      if (csr_valid) begin
         case (bcba_csr_type'(csr_index))
            CSR_BLOCK_SIZE:  bs_in   = csr_data[BS_W-1:0];
            CSR_BLOCK_COUNT: bc_in   = csr_data[BC_W-1:0];
            CSR_POOL_BASE:   base_in = csr_data[ADDR_W-1:0];
            default: ;
         endcase
      end

      if (cmd.req_load) begin
         func_in = req_func;
         size_in = req_size_bytes;
         addr_in = req_address;
      end
      if (cmd.need_load) begin
         need_in = quotient[CNT_W-1:0];
      end
      if (cmd.first_load) begin
         first_in = quotient[IDX_W-1:0];
      end

      if (cmd.scan_init) begin
         rd_idx_in  = '0;
         tag_vld_in = 1'b0;
         run_in     = '0;
      end else if (cmd.scan_step) begin
         if (rd_idx_ff < cnt_eff) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
         tag_in     = rd_idx_ff[IDX_W-1:0];
         tag_vld_in = rd_idx_ff < cnt_eff;
         if (tag_vld_ff) begin
            run_in   = run_next;
            start_in = start_next;
         end
      end else begin
         tag_vld_in = 1'b0;
      end

      if (cmd.wr_load_alloc) begin
         wr_idx_in = CNT_W'(start_next);
         wr_end_in = CNT_W'(start_next) + need_ff;
         wr_bit_in = 1'b1;
      end else if (cmd.wr_load_free) begin
         wr_idx_in = CNT_W'(first_ff);
         wr_end_in = span_end;
         wr_bit_in = 1'b0;
      end else if (cmd.wr_step) begin
         wr_idx_in = wr_idx_ff + CNT_W'(1);
      end

      if (cmd.mul_load) begin
         prod_in = MUL_W'(bs_eff) * MUL_W'(start_ff);
      end

      if (cmd.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.rsp_status;
         if ((cmd.rsp_status == STATUS_OK) && (bcba_func_type'(func_ff) == FUNC_ALLOC)) begin
            rsp_region_in = base_ff + ADDR_W'(prod_ff);
         end else begin
            rsp_region_in = '0;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff        <= BLOCK_SIZE_RESET;
         bc_ff        <= BLOCK_COUNT_RESET;
         base_ff      <= POOL_BASE_RESET;
         tag_vld_ff   <= 1'b0;
         wr_idx_ff    <= '0;
         wr_end_ff    <= CNT_W'(MAX_BLOCKS);
         wr_bit_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bs_ff        <= bs_in;
         bc_ff        <= bc_in;
         base_ff      <= base_in;
         tag_vld_ff   <= tag_vld_in;
         wr_idx_ff    <= wr_idx_in;
         wr_end_ff    <= wr_end_in;
         wr_bit_ff    <= wr_bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      need_ff       <= need_in;
      first_ff      <= first_in;
      rd_idx_ff     <= rd_idx_in;
      tag_ff        <= tag_in;
      run_ff        <= run_in;
      start_ff      <= start_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_region_ff <= rsp_region_in;
   end

   always_comb begin
      sts.req_zero       = size_ff == '0;
      sts.req_free       = bcba_func_type'(func_ff) == FUNC_FREE;
      sts.below_base     = addr_ff < base_ff;
      sts.div_done       = div_done;
      sts.quot_gt_cnt    = quotient > DIV_W'(cnt_eff);
      sts.quot_ge_cnt    = quot_ge_cnt;
      sts.scan_found     = scan_found;
      sts.scan_exhausted = scan_exhausted;
      sts.wr_last        = ((CNT_W + 1)'(wr_idx_ff) + (CNT_W + 1)'(1))
                           == (CNT_W + 1)'(wr_end_ff);
      sts.rsp_free       = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_region_address = rsp_region_ff;

endmodule

// File: rtl/core/bcba_controller.sv
// Controller state machine of the allocator; sequences the datapath through
// division, map scan, map write and response. Depends on bcba_pkg.
module bcba_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bcba_pkg::bcba_sts_type sts,
   output bcba_pkg::bcba_cmd_type cmd
);
   import bcba_pkg::*;

   bcba_state_type  state_ff, state_in;
   bcba_status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
         code_ff  <= STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.div_src    = DIVSRC_CEIL;
      cmd.rsp_status = code_ff;
      case (state_ff)
         STATE_CLEAR: begin
            cmd.wr_step = 1'b1;
            if (sts.wr_last) begin
               state_in = STATE_IDLE;
            end
         end
         STATE_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = STATE_PREP;
            end
         end
         STATE_PREP: begin
            if (sts.req_zero) begin
               code_in  = STATUS_ZERO;
               state_in = STATE_DONE;
            end else if (!sts.req_free) begin
               cmd.div_start = 1'b1;
               state_in      = STATE_DIV_NEED;
            end else if (sts.below_base) begin
               code_in  = STATUS_OUTSIDE;
               state_in = STATE_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIVSRC_OFFSET;
               state_in      = STATE_DIV_FIRST;
            end
         end
         STATE_DIV_NEED: begin
            if (sts.div_done) begin
               if (sts.quot_gt_cnt) begin
                  code_in  = STATUS_NO_RUN;
                  state_in = STATE_DONE;
               end else begin
                  cmd.need_load = 1'b1;
                  cmd.scan_init = 1'b1;
                  state_in      = STATE_SCAN;
               end
            end
         end
         STATE_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_found) begin
               cmd.wr_load_alloc = 1'b1;
               state_in          = STATE_WRITE;
            end else if (sts.scan_exhausted) begin
               code_in  = STATUS_NO_RUN;
               state_in = STATE_DONE;
            end
         end
         STATE_DIV_FIRST: begin
            if (sts.div_done) begin
               if (sts.quot_ge_cnt) begin
                  code_in  = STATUS_OUTSIDE;
                  state_in = STATE_DONE;
               end else begin
                  cmd.first_load = 1'b1;
                  cmd.div_start  = 1'b1;
                  state_in       = STATE_DIV_SPAN;
               end
            end
         end
         STATE_DIV_SPAN: begin
            if (sts.div_done) begin
               cmd.wr_load_free = 1'b1;
               state_in         = STATE_WRITE;
            end
         end
         STATE_WRITE: begin
            cmd.wr_step = 1'b1;
            if (sts.wr_last) begin
               if (sts.req_free) begin
                  code_in  = STATUS_OK;
                  state_in = STATE_DONE;
               end else begin
                  state_in = STATE_MUL;
               end
            end
         end
         STATE_MUL: begin
            cmd.mul_load = 1'b1;
            code_in      = STATUS_OK;
            state_in     = STATE_DONE;
         end
         STATE_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/bitmap_contiguous_block_allocator.sv
// Top level of the bitmap contiguous block allocator.
// Depends on bcba_pkg, assert_macros.svh, bcba_controller and bcba_datapath.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid/req_ready    req_func, req_size_bytes, req_address
//   rsp      out        rsp_valid/rsp_ready    rsp_status, rsp_region_address
//   csr      in         csr_valid/csr_ready    csr_index, csr_data
//
// An allocate runs one division, a map scan and a map write; a free runs two divisions
// and a map write. Each division yields one quotient bit a cycle, and the map RAM moves
// one bit a cycle. After reset a clearing pass zeroes the map, during which no request
// is taken. A stalled response holds in the output register; the next request is
// accepted meanwhile and its result waits until that register is free.
`include "assert_macros.svh"

module bitmap_contiguous_block_allocator #(
   parameter int MAX_BLOCKS = bcba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_func,
   input  logic [bcba_pkg::SIZE_W-1:0]     req_size_bytes,
   input  logic [bcba_pkg::ADDR_W-1:0]     req_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bcba_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bcba_pkg::ADDR_W-1:0]     rsp_region_address,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bcba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bcba_pkg::CSR_DATA_W-1:0] csr_data
);
   import bcba_pkg::*;

   bcba_cmd_type cmd;
   bcba_sts_type sts;

   assign csr_ready = 1'b1;

   bcba_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bcba_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_func           (req_func),
      .req_size_bytes     (req_size_bytes),
      .req_address        (req_address),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_region_address (rsp_region_address),
      .cmd                (cmd),
      .sts                (sts)
   );

   `BCBA_ASSERT_IMPL(a_region_zero, clock, reset, rsp_valid && (rsp_status != STATUS_OK), rsp_region_address == '0)
   `BCBA_ASSERT(a_single_map_op, clock, reset, !(cmd.wr_step && cmd.scan_step))
   `BCBA_ASSERT_IMPL(a_div_busy, clock, reset, sts.div_done, !req_ready)
   `BCBA_ASSERT_NEXT(a_rsp_load, clock, reset, cmd.rsp_load, rsp_valid)

endmodule
